[rtl/core/trsq_pkg.sv]
// ----------------------------------------------------------------------------
// trsq_pkg: shared types and constants of the timed-release sorted queue
// Field widths, operation and status codes, the sort key and the control
// word that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package trsq_pkg;

  localparam int ID_W     = 8;
  localparam int TIME_W   = 31;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Operation carried by an input transfer
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  // Sort key: time is the major field, so a packed compare orders by
  // (time, id) directly.
  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [ID_W-1:0]   id;
  } key_t;

  // Broadcast control word for the cell row
  typedef struct packed {
    logic ins;   // insert key into the row
    logic pop;   // shift row toward the head
    key_t key;   // key being inserted
  } ctl_t;

endpackage

[rtl/core/trsq_if.sv]
// ----------------------------------------------------------------------------
// trsq_in_if / trsq_out_if: valid/ready channels of the sorted queue
// Input carries one insert or pop request, output carries one result.
// ----------------------------------------------------------------------------
interface trsq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [trsq_pkg::ID_W-1:0]    entry_id;
  logic [trsq_pkg::TIME_W-1:0]  release_at;
  logic [trsq_pkg::TIME_W-1:0]  time_now;

  modport source (output valid, kind, entry_id, release_at, time_now, input ready);
  modport sink   (input valid, kind, entry_id, release_at, time_now, output ready);
endinterface

interface trsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [trsq_pkg::STATUS_W-1:0] status;
  logic [trsq_pkg::ID_W-1:0]     out_id;
  logic [trsq_pkg::TIME_W-1:0]   out_release;
  logic [trsq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_id, out_release, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_release, occupancy, output ready);
endinterface

[rtl/core/timed_release_sorted_queue.sv]
// ----------------------------------------------------------------------------
// timed_release_sorted_queue: fixed-depth queue sorted by release time
// Entries kept in (release time, id) order in a row of cells.
// ----------------------------------------------------------------------------
// Each input transfer is an insert or a pop and gives one result. A transfer
// is taken every cycle while the result register is free or being drained:
// all QUEUE_DEPTH cells compare their key with the new one in parallel and
// shift one place in the same cycle, and the result shows up on the output
// in the cycle after the input transfer. An insert into a full queue is
// rejected (status full), a pop returns the head only when its release time
// is at or before time_now. Entries with equal keys leave in arrival order.
// No clearing pass after reset.
module timed_release_sorted_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  trsq_in_if.sink      in_ch,
  trsq_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  trsq_pkg::key_t            keys [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    stops;
  trsq_pkg::ctl_t            ctl;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r;
  trsq_pkg::status_t         status_r, status_nxt;
  logic [trsq_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [trsq_pkg::TIME_W-1:0] rel_r, rel_nxt;

  logic accept, full, released;

  // handshake: result register frees as it is drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign released = (count_r != '0) && (keys[0].tm <= in_ch.time_now);

  // broadcast control to the cell row
  always_comb begin
    ctl.key.tm = in_ch.release_at;
    ctl.key.id = in_ch.entry_id;
    ctl.ins    = accept && (in_ch.kind == trsq_pkg::KIND_INSERT) && !full;
    ctl.pop    = accept && (in_ch.kind == trsq_pkg::KIND_POP) && released;
  end

  // cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    trsq_pkg::key_t left_key, right_key;
    logic           left_stop;
    if (i == 0) begin : g_head
      assign left_key  = '0;
      assign left_stop = 1'b1;
    end else begin : g_body
      assign left_key  = keys[i-1];
      assign left_stop = stops[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_key = '0;
    end else begin : g_mid
      assign right_key = keys[i+1];
    end
    trsq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CNT_W'(i) < count_r),
      .left_key  (left_key),
      .left_stop (left_stop),
      .right_key (right_key),
      .key       (keys[i]),
      .stop      (stops[i])
    );
  end

  // fill count and result
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    id_nxt     = id_r;
    rel_nxt    = rel_r;
    if (accept) begin
      id_nxt  = '0;
      rel_nxt = '0;
      if (in_ch.kind == trsq_pkg::KIND_INSERT) begin
        if (full) begin
          status_nxt = trsq_pkg::ST_FULL;
        end else begin
          status_nxt = trsq_pkg::ST_INSERTED;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else begin
        if (released) begin
          status_nxt = trsq_pkg::ST_RELEASED;
          id_nxt     = keys[0].id;
          rel_nxt    = keys[0].tm;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          status_nxt = trsq_pkg::ST_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    status_r <= status_nxt;
    id_r     <= id_nxt;
    rel_r    <= rel_nxt;
  end

  // occupancy register tracks the count after each transfer
  logic [trsq_pkg::OCC_W-1:0] occ_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      occ_r <= trsq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.out_id      = id_r;
  assign out_ch.out_release = rel_r;
  assign out_ch.occupancy   = occ_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> keys[0] <= keys[1])
    else $error("head pair out of order");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == trsq_pkg::ST_FULL |->
      occ_r == trsq_pkg::OCC_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != trsq_pkg::ST_RELEASED |-> id_r == '0 && rel_r == '0)
    else $error("payload not cleared without release");

endmodule

[rtl/core/trsq_cell.sv]
// ----------------------------------------------------------------------------
// trsq_cell: one slot of the sorted row
// Holds one key, reports whether it sorts at or before the key being
// inserted, and loads its own key, the new key or a neighbor's key.
// ----------------------------------------------------------------------------
module trsq_cell (
  input  logic             clk,
  input  trsq_pkg::ctl_t   ctl,
  input  logic             occupied,   // slot holds a live entry
  input  trsq_pkg::key_t   left_key,   // key of the slot nearer the head
  input  logic             left_stop,  // left slot keeps its key (or this is the head)
  input  trsq_pkg::key_t   right_key,  // key of the slot farther from the head
  output trsq_pkg::key_t   key,
  output logic             stop
);

  trsq_pkg::key_t key_r;
  trsq_pkg::key_t key_nxt;

  // stored key stays ahead of the new one: equal keys keep arrival order
  assign stop = occupied && (key_r <= ctl.key);
  assign key  = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (!stop) begin
        key_nxt = left_stop ? ctl.key : left_key;
      end
    end else if (ctl.pop) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

[bench/timed_release_sorted_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_release_sorted_queue_tb: self-checking bench of the sorted queue
// A short table of directed rows walks the queue through empty, full,
// not-yet-due and extreme keys. Phases of random inserts and pops follow,
// with fill and drain bursts and random idling on both channels. Each result
// is checked field by field against its typed row or an in-bench queue copy.
// ----------------------------------------------------------------------------
module timed_release_sorted_queue_tb;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 255;
  localparam int PHASES       = 6;
  localparam int DIR_N        = 25;
  localparam logic [trsq_pkg::TIME_W-1:0] TMAX  = {trsq_pkg::TIME_W{1'b1}};
  localparam logic [trsq_pkg::ID_W-1:0]   IDMAX = {trsq_pkg::ID_W{1'b1}};

  // One result of the queue
  typedef struct packed {
    trsq_pkg::status_t               status;
    logic [trsq_pkg::ID_W-1:0]       id;
    logic [trsq_pkg::TIME_W-1:0]     rel;
    logic [trsq_pkg::OCC_W-1:0]      occ;
  } outcome_t;

  // One directed row; typed rows carry their own expected result
  typedef struct packed {
    logic                            kind;
    logic [trsq_pkg::ID_W-1:0]       id;
    logic [trsq_pkg::TIME_W-1:0]     rel;
    logic [trsq_pkg::TIME_W-1:0]     now;
    logic                            typed;
    outcome_t                        res;
  } row_t;

  localparam outcome_t UNTYPED = '{trsq_pkg::ST_INSERTED, 8'd0, 31'd0, 5'd0};

  // Directed rows: empty pop, extreme keys, due and not-due heads,
  // equal keys, a fill to the top and an insert into the full queue
  row_t dir_rows [DIR_N] = '{
    '{trsq_pkg::KIND_POP,    8'hA5, 31'h5555_5555, 31'd0,         1'b1,
      '{trsq_pkg::ST_NONE,     8'd0,  31'd0, 5'd0}},
    '{trsq_pkg::KIND_INSERT, 8'd0,  31'd0,         TMAX,          1'b1,
      '{trsq_pkg::ST_INSERTED, 8'd0,  31'd0, 5'd1}},
    '{trsq_pkg::KIND_INSERT, IDMAX, TMAX,          31'h2AAA_AAAA, 1'b1,
      '{trsq_pkg::ST_INSERTED, 8'd0,  31'd0, 5'd2}},
    '{trsq_pkg::KIND_POP,    IDMAX, TMAX,          31'd0,         1'b1,
      '{trsq_pkg::ST_RELEASED, 8'd0,  31'd0, 5'd1}},
    '{trsq_pkg::KIND_POP,    8'd0,  31'd0,         TMAX - 31'd1,  1'b1,
      '{trsq_pkg::ST_NONE,     8'd0,  31'd0, 5'd1}},
    '{trsq_pkg::KIND_POP,    IDMAX, 31'd0,         TMAX,          1'b1,
      '{trsq_pkg::ST_RELEASED, IDMAX, TMAX,  5'd0}},
    '{trsq_pkg::KIND_INSERT, 8'd9,   31'd500,        31'd3,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd3,   31'd500,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd9,   31'd500,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd200, 31'd100,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd0,   TMAX,           31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd1,   31'd0,          31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd128, 31'h4000_0000,  31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd64,  31'd1,          31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd9,   31'd499,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd10,  31'd500,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, IDMAX,  31'd0,          31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd2,   31'h3FFF_FFFF,  31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd77,  31'd700,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd77,  31'd700,        31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd5,   31'd1000,       31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd6,   31'd2,          31'd0,  1'b0, UNTYPED},
    '{trsq_pkg::KIND_INSERT, 8'd1,   31'd1,          TMAX,   1'b1,
      '{trsq_pkg::ST_FULL,     8'd0,  31'd0, 5'd16}},
    '{trsq_pkg::KIND_POP,    8'd0,   31'd0,          31'd499, 1'b0, UNTYPED},
    '{trsq_pkg::KIND_POP,    IDMAX,  TMAX,           TMAX,    1'b0, UNTYPED}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;
  int   rx_mode = 0;
  int   rx_hold = 0;
  int   cycle_cnt = 0;
  int   mismatch_count = 0;

  // Expectation attached to the item on the input channel
  logic     pend_typed = 1'b0;
  outcome_t pend_res   = UNTYPED;

  // Bench copy of the queue contents
  trsq_pkg::key_t held_keys [QUEUE_DEPTH];
  int             held_count = 0;
  outcome_t       pending_outcomes [$];

  // Recent insert times, used to aim pops at heads that are just due
  logic [trsq_pkg::TIME_W-1:0] recent_times [8];
  int                          recent_idx = 0;

  trsq_in_if  in_ch ();
  trsq_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  timed_release_sorted_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mode 0 never idles, 1 idles lightly, 2 heavily
  function automatic int idle_len(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return 0;
      1: begin
        if (r < 75) return 0;
        else if (r < 95) return $urandom_range(1, 3);
        else return $urandom_range(8, 30);
      end
      default: begin
        if (r < 40) return 0;
        else if (r < 85) return $urandom_range(1, 4);
        else return $urandom_range(10, 40);
      end
    endcase
  endfunction

  // Apply one item to the bench queue and return the result it gives
  function automatic outcome_t queue_outcome(input logic kind,
                                             input logic [trsq_pkg::ID_W-1:0] id,
                                             input logic [trsq_pkg::TIME_W-1:0] rel,
                                             input logic [trsq_pkg::TIME_W-1:0] now);
    outcome_t       r;
    trsq_pkg::key_t nk;
    int             pos;
    r = UNTYPED;
    if (kind == trsq_pkg::KIND_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = trsq_pkg::ST_FULL;
      end else begin
        // new key goes behind every key not larger than itself
        nk.tm = rel;
        nk.id = id;
        pos = held_count;
        while (pos > 0) begin
          if (held_keys[pos-1] <= nk) break;
          held_keys[pos] = held_keys[pos-1];
          pos--;
        end
        held_keys[pos] = nk;
        held_count++;
        r.status = trsq_pkg::ST_INSERTED;
      end
    end else if (held_count == 0 || held_keys[0].tm > now) begin
      r.status = trsq_pkg::ST_NONE;
    end else begin
      r.status = trsq_pkg::ST_RELEASED;
      r.id     = held_keys[0].id;
      r.rel    = held_keys[0].tm;
      for (int k = 1; k < held_count; k++) held_keys[k-1] = held_keys[k];
      held_count--;
    end
    r.occ = trsq_pkg::OCC_W'(held_count);
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Scoreboard: record each input transfer, check each result transfer
  always @(posedge clk) begin : scoreboard
    outcome_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = queue_outcome(in_ch.kind, in_ch.entry_id, in_ch.release_at,
                             in_ch.time_now);
        if (pend_typed) want = pend_res;
        pending_outcomes.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got status %0d id %0d",
                   $time, out_ch.status, out_ch.out_id);
        end else begin
          want = pending_outcomes.pop_front();
          report_field("status",      32'(want.status), 32'(out_ch.status));
          report_field("out_id",      32'(want.id),     32'(out_ch.out_id));
          report_field("out_release", 32'(want.rel),    32'(out_ch.out_release));
          report_field("occupancy",   32'(want.occ),    32'(out_ch.occupancy));
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin : rx_stall
    int n;
    if (rx_hold > 0) begin
      sink_ready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else begin
      n = idle_len(rx_mode);
      sink_ready <= (n == 0);
      rx_hold    <= (n > 0) ? n - 1 : 0;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timed_release_sorted_queue verification failed");
      $finish;
    end
  end

  // Drive one item and hold it until its transfer
  task automatic send_item(input logic kind, input logic [trsq_pkg::ID_W-1:0] id,
                           input logic [trsq_pkg::TIME_W-1:0] rel,
                           input logic [trsq_pkg::TIME_W-1:0] now,
                           input logic typed, input outcome_t res, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.entry_id   <= id;
    in_ch.release_at <= rel;
    in_ch.time_now   <= now;
    pend_typed       <= typed;
    pend_res         <= res;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (kind == trsq_pkg::KIND_INSERT) begin
      recent_times[recent_idx] = rel;
      recent_idx = (recent_idx + 1) % 8;
    end
  endtask

  // Hold the input idle until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [trsq_pkg::TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return trsq_pkg::TIME_W'($urandom_range(0, 15));
      4:          return '0;
      5:          return TMAX;
      6:          return TMAX - trsq_pkg::TIME_W'($urandom_range(0, 15));
      default:    return trsq_pkg::TIME_W'($urandom);
    endcase
  endfunction

  function automatic logic [trsq_pkg::ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: return trsq_pkg::ID_W'($urandom_range(0, 3));
      5:             return IDMAX;
      6:             return '0;
      default:       return trsq_pkg::ID_W'($urandom);
    endcase
  endfunction

  // Pop time: mostly near recently inserted times, so heads are often
  // exactly due, just not due, or long due
  function automatic logic [trsq_pkg::TIME_W-1:0] pick_now();
    logic [trsq_pkg::TIME_W-1:0] t;
    int r;
    r = $urandom_range(0, 9);
    t = recent_times[$urandom_range(0, 7)];
    case (r)
      0, 1:    return t;
      2:       return (t != '0) ? t - trsq_pkg::TIME_W'(1) : t;
      3:       return (t != TMAX) ? t + trsq_pkg::TIME_W'(1) : t;
      4:       return TMAX;
      5:       return '0;
      6, 7:    return trsq_pkg::TIME_W'($urandom_range(0, 31));
      default: return trsq_pkg::TIME_W'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int ins_pct  [PHASES];
    int tx_modes [PHASES];
    int rx_modes [PHASES];
    int burst_left;
    int r;
    logic burst_kind;
    logic kind;
    logic [trsq_pkg::TIME_W-1:0] now;

    ins_pct    = '{70, 50, 85, 30, 55, 50};
    tx_modes   = '{0, 1, 2, 1, 0, 2};
    rx_modes   = '{1, 0, 2, 2, 0, 1};
    burst_left = 0;
    burst_kind = trsq_pkg::KIND_INSERT;
    foreach (recent_times[k]) recent_times[k] = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = trsq_pkg::KIND_INSERT;
    in_ch.entry_id   = '0;
    in_ch.release_at = '0;
    in_ch.time_now   = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].rel, dir_rows[i].now,
                dir_rows[i].typed, dir_rows[i].res, idle_len(1));
    end
    drain_results();

    // random phases with fill and drain bursts
    for (int p = 0; p < PHASES; p++) begin
      rx_mode <= rx_modes[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            burst_left = $urandom_range(14, 18);
            burst_kind = trsq_pkg::KIND_INSERT;
          end else if (r < 8) begin
            burst_left = $urandom_range(10, 18);
            burst_kind = trsq_pkg::KIND_POP;
          end else if (r == 8) begin
            drain_results();
          end
        end
        if (burst_left > 0) begin
          kind = burst_kind;
          burst_left--;
        end else begin
          kind = ($urandom_range(0, 99) < ins_pct[p]) ? trsq_pkg::KIND_INSERT
                                                      : trsq_pkg::KIND_POP;
        end
        if (kind == trsq_pkg::KIND_INSERT) begin
          send_item(kind, pick_id(), pick_time(), trsq_pkg::TIME_W'($urandom), 1'b0,
                    UNTYPED, idle_len(tx_modes[p]));
        end else begin
          now = (burst_left > 0 && $urandom_range(0, 1) == 0) ? TMAX : pick_now();
          send_item(kind, trsq_pkg::ID_W'($urandom), trsq_pkg::TIME_W'($urandom), now,
                    1'b0, UNTYPED, idle_len(tx_modes[p]));
        end
      end
      drain_results();
    end

    // let any stray result show up
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("timed_release_sorted_queue verification clean");
    end else begin
      $display("timed_release_sorted_queue verification failed");
    end
    $finish;
  end

endmodule

[timed_release_sorted_queue.f]
rtl/core/trsq_pkg.sv
rtl/core/trsq_if.sv
rtl/core/trsq_cell.sv
rtl/core/timed_release_sorted_queue.sv
bench/timed_release_sorted_queue_tb.sv
